@@ hw/rtl/edt_pkg.sv @@
// edt_pkg: word types, field widths and the month table of the epoch-to-date pipeline.
// No dependencies; edt_clk, edt_date and epoch_seconds_to_civil_date import it.
package edt_pkg;

    localparam int DAYS_W  = 16;   // day count since the epoch, at most 49710
    localparam int TOD_W   = 17;   // second of day, at most 86399
    localparam int DOY_W   = 9;    // day within the March-based year
    localparam int MP_W    = 4;    // March-based month index
    localparam int MONTHS  = 12;

    typedef struct packed {
        logic [31:0] epoch_seconds;
        logic [19:0] micro_in;
    } stamp_t;

    typedef struct packed {
        logic [11:0] year_out;
        logic [3:0]  month_out;
        logic [4:0]  day_out;
        logic [4:0]  hour_out;
        logic [5:0]  minute_out;
        logic [5:0]  second_out;
        logic [19:0] micro_out;
    } civil_t;

    // Time-of-day fields that ride along with the date computation
    typedef struct packed {
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [19:0] micro;
    } tod_fields_t;

    // First day of each March-based month within the year (March is index 0)
    function automatic logic [DOY_W-1:0] month_start(input logic [MP_W-1:0] mp);
        logic [DOY_W-1:0] first;
        case (mp)
            4'd0:    first = 9'd0;
            4'd1:    first = 9'd31;
            4'd2:    first = 9'd61;
            4'd3:    first = 9'd92;
            4'd4:    first = 9'd122;
            4'd5:    first = 9'd153;
            4'd6:    first = 9'd184;
            4'd7:    first = 9'd214;
            4'd8:    first = 9'd245;
            4'd9:    first = 9'd275;
            4'd10:   first = 9'd306;
            4'd11:   first = 9'd337;
            default: first = 9'd0;
        endcase
        return first;
    endfunction

endpackage

@@ hw/rtl/edt_cdiv.sv @@
// edt_cdiv: two-stage divider by a constant (reciprocal multiply, then one correction step).
// Standalone; shares the pipeline enable of its instantiating module.
module edt_cdiv #(
    parameter int XW  = 25,
    parameter int DIV = 675,
    parameter int QW  = 16,
    parameter int RW  = 10,
    parameter int SW  = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          src_valid,
    input  logic [XW-1:0] x,
    input  logic [SW-1:0] side,
    output logic          res_valid,
    output logic [QW-1:0] quo,
    output logic [RW-1:0] rem,
    output logic [SW-1:0] res_side
);

    localparam int PW = 2 * XW;
    // floor(2^XW / DIV): the estimate is then low by at most one
    localparam logic [XW-1:0] RECIP = XW'((64'd1 << XW) / DIV);
    localparam logic [XW-1:0] DIV_C = XW'(DIV);

    logic          mul_valid_reg;
    logic [PW-1:0] prod_reg;
    logic [PW-1:0] prod_next;
    logic [XW-1:0] x_reg;
    logic [SW-1:0] side1_reg;

    logic          res_valid_reg;
    logic [QW-1:0] quo_reg;
    logic [QW-1:0] quo_next;
    logic [RW-1:0] rem_reg;
    logic [RW-1:0] rem_next;
    logic [SW-1:0] side2_reg;

    logic [XW-1:0] q_est;
    logic [PW-1:0] back_prod;
    logic [XW-1:0] r_est;
    logic          fix;
    logic [XW-1:0] q_fix;
    logic [XW-1:0] r_fix;

    assign prod_next = PW'(x) * PW'(RECIP);

    assign q_est     = prod_reg[PW-1:XW];
    assign back_prod = PW'(q_est) * PW'(DIV_C);
    assign r_est     = x_reg - back_prod[XW-1:0];
    assign fix       = (r_est >= DIV_C);
    assign q_fix     = q_est + XW'(fix);
    assign r_fix     = fix ? (r_est - DIV_C) : r_est;
    assign quo_next  = q_fix[QW-1:0];
    assign rem_next  = r_fix[RW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            mul_valid_reg <= src_valid;
            res_valid_reg <= mul_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg  <= prod_next;
            x_reg     <= x;
            side1_reg <= side;
            quo_reg   <= quo_next;
            rem_reg   <= rem_next;
            side2_reg <= side1_reg;
        end
    end

    assign res_valid = res_valid_reg;
    assign quo       = quo_reg;
    assign rem       = rem_reg;
    assign res_side  = side2_reg;

endmodule

@@ hw/rtl/edt_clk.sv @@
// edt_clk: splits the second of day into hour, minute and second (four stages).
// Depends on edt_pkg and edt_cdiv.
module edt_clk (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       src_valid,
    input  logic [edt_pkg::TOD_W-1:0]  tod,
    input  logic [edt_pkg::DAYS_W-1:0] days,
    input  logic [19:0]                micro,
    output logic                       res_valid,
    output logic [edt_pkg::DAYS_W-1:0] res_days,
    output edt_pkg::tod_fields_t       fields
);

    import edt_pkg::*;

    localparam int HSW = DAYS_W + 20;
    localparam int MSW = 5 + HSW;

    logic           h_valid;
    logic [4:0]     h_quo;
    logic [11:0]    h_rem;
    logic [HSW-1:0] h_side;

    logic           m_valid;
    logic [5:0]     m_quo;
    logic [5:0]     m_rem;
    logic [MSW-1:0] m_side;

    edt_cdiv #(.XW(TOD_W), .DIV(3600), .QW(5), .RW(12), .SW(HSW)) u_hour (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .src_valid (src_valid),
        .x         (tod),
        .side      ({days, micro}),
        .res_valid (h_valid),
        .quo       (h_quo),
        .rem       (h_rem),
        .res_side  (h_side)
    );

    edt_cdiv #(.XW(12), .DIV(60), .QW(6), .RW(6), .SW(MSW)) u_minute (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .src_valid (h_valid),
        .x         (h_rem),
        .side      ({h_quo, h_side}),
        .res_valid (m_valid),
        .quo       (m_quo),
        .rem       (m_rem),
        .res_side  (m_side)
    );

    assign res_valid     = m_valid;
    assign res_days      = m_side[HSW-1:20];
    assign fields.hour   = m_side[MSW-1:HSW];
    assign fields.minute = m_quo;
    assign fields.second = m_rem;
    assign fields.micro  = m_side[19:0];

endmodule

@@ hw/rtl/edt_date.sv @@
// edt_date: turns a day count since the epoch into year, month and day (nine stages).
// Depends on edt_pkg and edt_cdiv.
module edt_date (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       src_valid,
    input  logic [edt_pkg::DAYS_W-1:0] days,
    input  edt_pkg::tod_fields_t       fields,
    output logic                       res_valid,
    output logic [11:0]                year,
    output logic [3:0]                 month,
    output logic [4:0]                 day,
    output edt_pkg::tod_fields_t       res_fields
);

    import edt_pkg::*;

    localparam int DOE_W = 18;
    localparam int YOE_W = 9;
    localparam int FW    = $bits(tod_fields_t);
    localparam int SW    = DOE_W + 1 + FW;

    // Inputs span only eras 4 and 5; era 5 starts 11017 days after the epoch
    localparam logic [DAYS_W-1:0] ERA5_DAY  = 16'd11017;
    localparam logic [DOE_W-1:0]  ERA4_OFS  = 18'd135080;
    localparam logic [11:0]       ERA4_YEAR = 12'd1600;
    localparam logic [11:0]       ERA5_YEAR = 12'd2000;

    // Stage P: era and day of era
    logic             p_valid_reg;
    logic [DOE_W-1:0] p_doe_reg;
    logic [DOE_W-1:0] p_doe_next;
    logic             p_era5_reg;
    logic             p_era5_next;
    tod_fields_t      p_fields_reg;

    // Divide day of era by 1460
    logic             a_valid;
    logic [6:0]       a_quo;
    logic [SW-1:0]    a_side;

    // Stage N: numerator of the year-of-era division
    logic             n_valid_reg;
    logic [DOE_W-1:0] n_num_reg;
    logic [DOE_W-1:0] n_num_next;
    logic [SW-1:0]    n_side_reg;
    logic [2:0]       n_c36524;
    logic             n_c146096;

    // Divide by 365
    logic             b_valid;
    logic [YOE_W-1:0] b_quo;
    logic [SW-1:0]    b_side;
    logic [DOE_W-1:0] b_doe;

    // Stage Y: day of year
    logic             y_valid_reg;
    logic [DOY_W-1:0] y_doy_reg;
    logic [DOY_W-1:0] y_doy_next;
    logic [YOE_W-1:0] y_yoe_reg;
    logic             y_era5_reg;
    tod_fields_t      y_fields_reg;
    logic [DOE_W-1:0] y_base;
    logic [1:0]       y_c100;

    // Stage M: March-based month
    logic             m_valid_reg;
    logic [MP_W-1:0]  m_mp_reg;
    logic [MP_W-1:0]  m_mp_next;
    logic [DOY_W-1:0] m_doy_reg;
    logic [YOE_W-1:0] m_yoe_reg;
    logic             m_era5_reg;
    tod_fields_t      m_fields_reg;

    // Stage F: final date fields
    logic             f_valid_reg;
    logic [11:0]      f_year_reg;
    logic [11:0]      f_year_next;
    logic [3:0]       f_month_reg;
    logic [3:0]       f_month_next;
    logic [4:0]       f_day_reg;
    logic [4:0]       f_day_next;
    tod_fields_t      f_fields_reg;
    logic [DOY_W-1:0] f_day_full;
    logic             f_jan_feb;

    assign p_era5_next = (days >= ERA5_DAY);
    assign p_doe_next  = p_era5_next ? DOE_W'(days - ERA5_DAY) : (DOE_W'(days) + ERA4_OFS);

    edt_cdiv #(.XW(DOE_W), .DIV(1460), .QW(7), .RW(11), .SW(SW)) u_div1460 (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .src_valid (p_valid_reg),
        .x         (p_doe_reg),
        .side      ({p_doe_reg, p_era5_reg, p_fields_reg}),
        .res_valid (a_valid),
        .quo       (a_quo),
        .rem       (),
        .res_side  (a_side)
    );

    // Century and era corrections as compares against their few thresholds
    always_comb
    begin
        logic [DOE_W-1:0] doe;
        doe = a_side[SW-1:SW-DOE_W];
        n_c36524 = 3'(doe >= 18'd36524) + 3'(doe >= 18'd73048)
                 + 3'(doe >= 18'd109572) + 3'(doe >= 18'd146096);
        n_c146096  = (doe == 18'd146096);
        n_num_next = doe - DOE_W'(a_quo) + DOE_W'(n_c36524) - DOE_W'(n_c146096);
    end

    edt_cdiv #(.XW(DOE_W), .DIV(365), .QW(YOE_W), .RW(9), .SW(SW)) u_div365 (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .src_valid (n_valid_reg),
        .x         (n_num_reg),
        .side      (n_side_reg),
        .res_valid (b_valid),
        .quo       (b_quo),
        .rem       (),
        .res_side  (b_side)
    );

    assign b_doe  = b_side[SW-1:SW-DOE_W];
    assign y_c100 = 2'(b_quo >= 9'd100) + 2'(b_quo >= 9'd200) + 2'(b_quo >= 9'd300);
    assign y_base = DOE_W'(b_quo) * DOE_W'(365) + DOE_W'(b_quo[YOE_W-1:2]) - DOE_W'(y_c100);
    assign y_doy_next = DOY_W'(b_doe - y_base);

    // Month index: count the month starts already reached
    always_comb
    begin
        m_mp_next = '0;
        for (int k = 1; k < MONTHS; k++)
        begin
            if (y_doy_reg >= month_start(MP_W'(k)))
                m_mp_next = m_mp_next + 4'd1;
        end
    end

    assign f_jan_feb    = (m_mp_reg >= 4'd10);
    assign f_month_next = f_jan_feb ? (m_mp_reg - 4'd9) : (m_mp_reg + 4'd3);
    assign f_day_full   = m_doy_reg - month_start(m_mp_reg) + 9'd1;
    assign f_day_next   = f_day_full[4:0];
    assign f_year_next  = 12'(m_yoe_reg) + (m_era5_reg ? ERA5_YEAR : ERA4_YEAR)
                        + 12'(f_jan_feb);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            n_valid_reg <= 1'b0;
            y_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            p_valid_reg <= src_valid;
            n_valid_reg <= a_valid;
            y_valid_reg <= b_valid;
            m_valid_reg <= y_valid_reg;
            f_valid_reg <= m_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_doe_reg    <= p_doe_next;
            p_era5_reg   <= p_era5_next;
            p_fields_reg <= fields;

            n_num_reg    <= n_num_next;
            n_side_reg   <= a_side;

            y_doy_reg    <= y_doy_next;
            y_yoe_reg    <= b_quo;
            y_era5_reg   <= b_side[FW];
            y_fields_reg <= b_side[FW-1:0];

            m_mp_reg     <= m_mp_next;
            m_doy_reg    <= y_doy_reg;
            m_yoe_reg    <= y_yoe_reg;
            m_era5_reg   <= y_era5_reg;
            m_fields_reg <= y_fields_reg;

            f_year_reg   <= f_year_next;
            f_month_reg  <= f_month_next;
            f_day_reg    <= f_day_next;
            f_fields_reg <= m_fields_reg;
        end
    end

    assign res_valid  = f_valid_reg;
    assign year       = f_year_reg;
    assign month      = f_month_reg;
    assign day        = f_day_reg;
    assign res_fields = f_fields_reg;

endmodule

@@ hw/rtl/epoch_seconds_to_civil_date.sv @@
// epoch_seconds_to_civil_date: Unix seconds plus microseconds to a Gregorian date and time.
// Depends on edt_pkg, edt_cdiv, edt_clk and edt_date.
//
//   channel | handshake                 | word
//   --------+---------------------------+--------------------------------------------
//   time    | time_valid / time_ready   | stamp_t: epoch_seconds, micro_in
//   date    | date_valid / date_ready   | civil_t: year, month, day, h, m, s, micro
//
// One word enters per clock unless the output stalls; each word passes in turn
// through the day split, hour/minute/second, calendar and the output register.
// Each stage holds at most one wide multiply, with its adds and compares; the
// constant divisions are reciprocal multiplies followed by one correction step.
// Reset clears only the valid bits; payload registers come up undefined.
// While a finished word waits at the output, every stage holds together, so a
// stall neither drops nor repeats a word; time_ready rises again as it is taken.
module epoch_seconds_to_civil_date (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             time_valid,
    output logic             time_ready,
    input  edt_pkg::stamp_t  time_word,
    output logic             date_valid,
    input  logic             date_ready,
    output edt_pkg::civil_t  date_word
);

    import edt_pkg::*;

    localparam int LOW_W = 7;            // 86400 = 675 * 2^7
    localparam int SSW   = LOW_W + 20;

    // Shared pipeline enable: advance unless the output word is stuck
    logic en;

    logic              s_valid;
    logic [DAYS_W-1:0] s_days;
    logic [9:0]        s_rem;
    logic [SSW-1:0]    s_side;
    logic [TOD_W-1:0]  s_tod;

    logic              c_valid;
    logic [DAYS_W-1:0] c_days;
    tod_fields_t       c_fields;

    logic              d_valid;
    logic [11:0]       d_year;
    logic [3:0]        d_month;
    logic [4:0]        d_day;
    tod_fields_t       d_fields;

    logic   out_valid_reg;
    civil_t out_word_reg;
    civil_t out_word_next;

    assign en         = !out_valid_reg || date_ready;
    assign time_ready = en;

    // Day split: drop the low seven bits, divide the rest by 675
    edt_cdiv #(.XW(32 - LOW_W), .DIV(675), .QW(DAYS_W), .RW(10), .SW(SSW)) u_days (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .src_valid (time_valid),
        .x         (time_word.epoch_seconds[31:LOW_W]),
        .side      ({time_word.epoch_seconds[LOW_W-1:0], time_word.micro_in}),
        .res_valid (s_valid),
        .quo       (s_days),
        .rem       (s_rem),
        .res_side  (s_side)
    );

    // Second of day: remainder by 675 with the dropped low bits put back
    assign s_tod = {s_rem, s_side[SSW-1:20]};

    edt_clk u_clk (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .src_valid (s_valid),
        .tod       (s_tod),
        .days      (s_days),
        .micro     (s_side[19:0]),
        .res_valid (c_valid),
        .res_days  (c_days),
        .fields    (c_fields)
    );

    edt_date u_date (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .src_valid  (c_valid),
        .days       (c_days),
        .fields     (c_fields),
        .res_valid  (d_valid),
        .year       (d_year),
        .month      (d_month),
        .day        (d_day),
        .res_fields (d_fields)
    );

    always_comb
    begin
        out_word_next.year_out   = d_year;
        out_word_next.month_out  = d_month;
        out_word_next.day_out    = d_day;
        out_word_next.hour_out   = d_fields.hour;
        out_word_next.minute_out = d_fields.minute;
        out_word_next.second_out = d_fields.second;
        out_word_next.micro_out  = d_fields.micro;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= d_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_word_reg <= out_word_next;
        end
    end

    assign date_valid = out_valid_reg;
    assign date_word  = out_word_reg;

    a_date_fields: assert property (@(posedge clk) disable iff (!rst_n)
        date_valid |-> (date_word.month_out >= 4'd1) && (date_word.month_out <= 4'd12)
                       && (date_word.day_out >= 5'd1))
        else $error("month or day out of range");

    a_time_fields: assert property (@(posedge clk) disable iff (!rst_n)
        date_valid |-> (date_word.hour_out <= 5'd23) && (date_word.minute_out <= 6'd59)
                       && (date_word.second_out <= 6'd59))
        else $error("time of day out of range");

    a_year_range: assert property (@(posedge clk) disable iff (!rst_n)
        date_valid |-> (date_word.year_out >= 12'd1970) && (date_word.year_out <= 12'd2106))
        else $error("year out of range");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (date_valid && !date_ready) |-> !time_ready)
        else $error("input taken while output stalled");

endmodule
